FILE: hdl/dprm_pkg.sv
package dprm_pkg;

    localparam int TARGET_WIDTH = 24;
    localparam logic [TARGET_WIDTH-1:0] TARGET_RESET = 24'd116508;
    localparam int OUT_WIDTH = 32;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DIV    = 7'b0000010,
        S_MUL_Y  = 7'b0000100,
        S_MUL_L  = 7'b0001000,
        S_MUL_R  = 7'b0010000,
        S_NEXT   = 7'b0100000,
        S_FINISH = 7'b1000000
    } t_state;

endpackage

FILE: hdl/dprm_div.sv
module dprm_div #(
    parameter int W = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [W-1:0]         i_dividend,
    input  logic [W-1:0]         i_divisor,
    output logic [W-1:0]         o_quot,
    output logic [W-1:0]         o_rem,
    output dprm_pkg::t_unit_stat o_stat
);

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  r_q;
    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_dv;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [W:0] rem_sh;
    logic [W:0] diff;
    logic       take;

    always_comb begin
        rem_sh = {r_rem, r_q[W-1]};
        diff   = rem_sh - {1'b0, r_dv};
        take   = (rem_sh >= {1'b0, r_dv});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == CW'(0));
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == CW'(0))) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_dv  <= i_divisor;
            r_rem <= '0;
            r_cnt <= CW'(W - 1);
        end else if (r_busy) begin
            r_rem <= take ? diff[W-1:0] : rem_sh[W-1:0];
            r_q   <= {r_q[W-2:0], take};
            r_cnt <= r_cnt - CW'(1);
        end
    end

    assign o_quot      = r_q;
    assign o_rem       = r_rem;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

FILE: hdl/dprm_mul.sv
module dprm_mul #(
    parameter int AW = 56,
    parameter int BW = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [AW-1:0]        i_a,
    input  logic [BW-1:0]        i_b,
    output logic [AW+BW-1:0]     o_prod,
    output dprm_pkg::t_unit_stat o_stat
);

    localparam int PW = AW + BW;
    localparam int CW = $clog2(BW + 1);

    logic [AW-1:0] r_a;
    logic [BW-1:0] r_b;
    logic [PW-1:0] r_acc;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [PW-1:0] acc_step;

    always_comb begin
        acc_step = {r_acc[PW-2:0], 1'b0} + (r_b[BW-1] ? PW'(r_a) : PW'(0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == CW'(0));
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == CW'(0))) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
            r_cnt <= CW'(BW - 1);
        end else if (r_busy) begin
            r_acc <= acc_step;
            r_b   <= {r_b[BW-2:0], 1'b0};
            r_cnt <= r_cnt - CW'(1);
        end
    end

    assign o_prod      = r_acc;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

FILE: hdl/divisor_pair_ratio_match_core.sv
// each trial divisor takes one pass through the restoring divider
// a divisor that splits the count adds up to three serial multiplies per orientation;
// trials run for a = 1 .. floor(sqrt(count)) + 1
// a zero count goes straight to the finish state; one transfer at a time, busy high until the result
// the result strobe lasts one cycle and cannot be stalled by the receiver
// synchronous active-low reset idles the sequencer and restores the target ratio
module divisor_pair_ratio_match_core #(
    parameter int COUNT_WIDTH     = 32,
    parameter int RATIO_FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [COUNT_WIDTH-1:0]              i_count,
    output logic                                o_busy,
    input  logic                                i_cfg_we,
    input  logic [dprm_pkg::TARGET_WIDTH-1:0]   i_cfg_wdata,
    output logic                                o_valid,
    output logic [dprm_pkg::OUT_WIDTH-1:0]      o_grid_rows,
    output logic [dprm_pkg::OUT_WIDTH-1:0]      o_grid_cols
);

    localparam int W  = COUNT_WIDTH;
    localparam int F  = RATIO_FRAC_BITS;
    localparam int TW = dprm_pkg::TARGET_WIDTH;
    localparam int DW = W + ((F > TW) ? F : TW);
    localparam int PW = DW + W;

    dprm_pkg::t_state r_state, n_state;

    logic [TW-1:0] r_target;
    logic          r_valid, n_valid;
    logic          r_div_start, n_div_start;
    logic          r_mul_start, n_mul_start;
    logic          r_have, n_have;
    logic          r_k, n_k;
    logic [W-1:0]  r_n, n_n;
    logic [W-1:0]  r_a, n_a;
    logic [W-1:0]  r_q, n_q;
    logic [W-1:0]  r_cols, n_cols;
    logic [W-1:0]  r_rows, n_rows;
    logic [DW-1:0] r_d, n_d;
    logic [PW-1:0] r_lhs, n_lhs;
    logic [DW-1:0] r_best_d, n_best_d;
    logic [W-1:0]  r_best_rows, n_best_rows;
    logic [W-1:0]  r_best_cols, n_best_cols;

    logic [W-1:0]  div_quot;
    logic [W-1:0]  div_rem;
    logic [DW-1:0] mul_a;
    logic [W-1:0]  mul_b;
    logic [PW-1:0] mul_prod;
    logic [DW-1:0] dist_x;
    logic [DW-1:0] dist_y;
    logic [DW-1:0] dist_d;

    dprm_pkg::t_unit_stat div_stat;
    dprm_pkg::t_unit_stat mul_stat;

    dprm_div #(
        .W(W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_n),
        .i_divisor  (r_a),
        .o_quot     (div_quot),
        .o_rem      (div_rem),
        .o_stat     (div_stat)
    );

    // operand select follows the state the start pulse was issued into
    always_comb begin
        case (r_state)
            dprm_pkg::S_MUL_L: begin
                mul_a = r_d;
                mul_b = r_best_rows;
            end
            dprm_pkg::S_MUL_R: begin
                mul_a = r_best_d;
                mul_b = r_rows;
            end
            default: begin
                mul_a = DW'(r_target);
                mul_b = r_rows;
            end
        endcase
    end

    dprm_mul #(
        .AW(DW),
        .BW(W)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_prod  (mul_prod),
        .o_stat  (mul_stat)
    );

    // |cols * 2^F - target * rows|
    always_comb begin
        dist_x = DW'({r_cols, {F{1'b0}}});
        dist_y = mul_prod[DW-1:0];
        dist_d = (dist_x >= dist_y) ? (dist_x - dist_y) : (dist_y - dist_x);
    end

    always_comb begin
        n_state     = r_state;
        n_valid     = 1'b0;
        n_div_start = 1'b0;
        n_mul_start = 1'b0;
        n_have      = r_have;
        n_k         = r_k;
        n_n         = r_n;
        n_a         = r_a;
        n_q         = r_q;
        n_cols      = r_cols;
        n_rows      = r_rows;
        n_d         = r_d;
        n_lhs       = r_lhs;
        n_best_d    = r_best_d;
        n_best_rows = r_best_rows;
        n_best_cols = r_best_cols;

        case (r_state)
            dprm_pkg::S_IDLE: begin
                if (i_start) begin
                    n_n         = i_count;
                    n_a         = W'(1);
                    n_have      = 1'b0;
                    n_best_rows = '0;
                    n_best_cols = '0;
                    n_best_d    = '0;
                    if (i_count == '0) begin
                        n_state = dprm_pkg::S_FINISH;
                    end else begin
                        n_state     = dprm_pkg::S_DIV;
                        n_div_start = 1'b1;
                    end
                end
            end
            dprm_pkg::S_DIV: begin
                if (div_stat.done) begin
                    n_q = div_quot;
                    if (r_a > div_quot) begin
                        n_state = dprm_pkg::S_FINISH;
                    end else if (div_rem != '0) begin
                        n_a         = r_a + W'(1);
                        n_div_start = 1'b1;
                    end else begin
                        n_k         = 1'b0;
                        n_cols      = r_a;
                        n_rows      = div_quot;
                        n_state     = dprm_pkg::S_MUL_Y;
                        n_mul_start = 1'b1;
                    end
                end
            end
            dprm_pkg::S_MUL_Y: begin
                if (mul_stat.done) begin
                    n_d = dist_d;
                    if (!r_have) begin
                        n_have      = 1'b1;
                        n_best_d    = dist_d;
                        n_best_rows = r_rows;
                        n_best_cols = r_cols;
                        n_state     = dprm_pkg::S_NEXT;
                    end else begin
                        n_state     = dprm_pkg::S_MUL_L;
                        n_mul_start = 1'b1;
                    end
                end
            end
            dprm_pkg::S_MUL_L: begin
                if (mul_stat.done) begin
                    n_lhs       = mul_prod;
                    n_state     = dprm_pkg::S_MUL_R;
                    n_mul_start = 1'b1;
                end
            end
            dprm_pkg::S_MUL_R: begin
                if (mul_stat.done) begin
                    // ties go to the later pair
                    if (!(r_lhs > mul_prod)) begin
                        n_best_d    = r_d;
                        n_best_rows = r_rows;
                        n_best_cols = r_cols;
                    end
                    n_state = dprm_pkg::S_NEXT;
                end
            end
            dprm_pkg::S_NEXT: begin
                if (!r_k && (r_a != r_q)) begin
                    n_k         = 1'b1;
                    n_cols      = r_q;
                    n_rows      = r_a;
                    n_state     = dprm_pkg::S_MUL_Y;
                    n_mul_start = 1'b1;
                end else begin
                    n_a         = r_a + W'(1);
                    n_state     = dprm_pkg::S_DIV;
                    n_div_start = 1'b1;
                end
            end
            dprm_pkg::S_FINISH: begin
                n_valid = 1'b1;
                n_state = dprm_pkg::S_IDLE;
            end
            default: begin
                n_state = dprm_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dprm_pkg::S_IDLE;
            r_target    <= dprm_pkg::TARGET_RESET;
            r_valid     <= 1'b0;
            r_div_start <= 1'b0;
            r_mul_start <= 1'b0;
            r_have      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_div_start <= n_div_start;
            r_mul_start <= n_mul_start;
            r_have      <= n_have;
            if (i_cfg_we) begin
                r_target <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_k         <= n_k;
        r_n         <= n_n;
        r_a         <= n_a;
        r_q         <= n_q;
        r_cols      <= n_cols;
        r_rows      <= n_rows;
        r_d         <= n_d;
        r_lhs       <= n_lhs;
        r_best_d    <= n_best_d;
        r_best_rows <= n_best_rows;
        r_best_cols <= n_best_cols;
    end

    assign o_busy      = (r_state != dprm_pkg::S_IDLE);
    assign o_valid     = r_valid;
    assign o_grid_rows = dprm_pkg::OUT_WIDTH'(r_best_rows);
    assign o_grid_cols = dprm_pkg::OUT_WIDTH'(r_best_cols);

    a_units_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(div_stat.busy && mul_stat.busy))
        else $error("divider and multiplier active together");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted transfer did not raise busy");

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!o_busy && !div_stat.busy && !mul_stat.busy))
        else $error("result shown while work still running");

endmodule
